### hw/rtl/yuv422_to_rgb_converter_defines.svh
// Assertion macros used by the converter's port-level checker.
`ifndef YUV422_TO_RGB_CONVERTER_DEFINES_SVH
`define YUV422_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication; the consequent may carry its own delay.
`define YUVRGB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication.
`define YUVRGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

### hw/rtl/yuvrgb_pkg.sv
// Package: payload types, coefficients and the divide-by-1000 helper.
`default_nettype none
package yuvrgb_pkg;

   // Conversion coefficients, scaled by 1000
   localparam int COEF_RV = 1403;
   localparam int COEF_GU = 344;
   localparam int COEF_GV = 714;
   localparam int COEF_BU = 1770;

   // floor(n / 1000) == (n * RECIP_1000) >> RECIP_SHIFT for all n < 2^18
   localparam logic [18:0] RECIP_1000  = 19'd268436;
   localparam int          RECIP_SHIFT = 28;

   // One macropixel in memory order
   typedef struct packed {
      logic [7:0] byte_zero;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
   } yuvrgb_req_type;

   // Two RGB pixels
   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
   } yuvrgb_rsp_type;

   // Samples after byte-order selection
   typedef struct packed {
      logic [7:0] y0;
      logic [7:0] y1;
      logic [7:0] u;
      logic [7:0] v;
   } yuvrgb_samp_type;

   // Chroma contributions shared by both pixels
   typedef struct packed {
      logic signed [8:0] r_offs;
      logic signed [8:0] g_offs;
      logic signed [8:0] b_offs;
   } yuvrgb_offs_type;

   // One RGB pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } yuvrgb_rgb_type;

   // Signed divide by 1000, truncating toward zero; |num| < 2^18
   function automatic logic signed [8:0] div1000_trunc(input logic signed [18:0] num);
      logic [17:0] mag;
      logic [36:0] prod;
      logic [8:0]  quo;
      mag  = num[18] ? 18'(-num) : num[17:0];
      prod = 37'(mag) * 37'(RECIP_1000);
      quo  = 9'(prod >> RECIP_SHIFT);
      return $signed(num[18] ? (9'd0 - quo) : quo);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/yuvrgb_unpack.sv
// Byte-order select: splits a macropixel into Y0, Y1, U and V.
`default_nettype none
module yuvrgb_unpack (
   input  wire yuvrgb_pkg::yuvrgb_req_type  macro_px,
   input  wire                              byte_order,
   output yuvrgb_pkg::yuvrgb_samp_type      samp
);
   import yuvrgb_pkg::*;

   // 0: Y0 U Y1 V, 1: U Y0 V Y1
   always_comb begin
      if (byte_order) begin
         samp.u  = macro_px.byte_zero;
         samp.y0 = macro_px.byte_one;
         samp.v  = macro_px.byte_two;
         samp.y1 = macro_px.byte_three;
      end else begin
         samp.y0 = macro_px.byte_zero;
         samp.u  = macro_px.byte_one;
         samp.y1 = macro_px.byte_two;
         samp.v  = macro_px.byte_three;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/yuvrgb_chroma.sv
// Chroma terms: bias removal, coefficient products and truncating divide.
`default_nettype none
module yuvrgb_chroma (
   input  wire [7:0]                    u,
   input  wire [7:0]                    v,
   output yuvrgb_pkg::yuvrgb_offs_type  offs
);
   import yuvrgb_pkg::*;

   logic signed [7:0]  uc;
   logic signed [7:0]  vc;
   logic signed [18:0] prod_r;
   logic signed [18:0] prod_g;
   logic signed [18:0] prod_b;

   // Subtracting 128 from an 8-bit sample is an MSB flip
   assign uc = $signed({~u[7], u[6:0]});
   assign vc = $signed({~v[7], v[6:0]});

   // Constant products, all within +/-2^18
   assign prod_r = 19'(vc) * 19'(COEF_RV);
   assign prod_g = 19'(uc) * 19'(COEF_GU) - 19'(vc) * 19'(COEF_GV);
   assign prod_b = 19'(uc) * 19'(COEF_BU);

   assign offs.r_offs = div1000_trunc(prod_r);
   assign offs.g_offs = div1000_trunc(prod_g);
   assign offs.b_offs = div1000_trunc(prod_b);

endmodule
`default_nettype wire

### hw/rtl/yuvrgb_pixel.sv
// One pixel: luma plus chroma terms, clamped to 0..255.
`default_nettype none
module yuvrgb_pixel (
   input  wire [7:0]                    luma,
   input  wire yuvrgb_pkg::yuvrgb_offs_type offs,
   output yuvrgb_pkg::yuvrgb_rgb_type   rgb
);
   import yuvrgb_pkg::*;

   logic signed [9:0] sum_r;
   logic signed [9:0] sum_g;
   logic signed [9:0] sum_b;

   // Sums span -226..479
   assign sum_r = $signed({2'b00, luma}) + 10'(offs.r_offs);
   assign sum_g = $signed({2'b00, luma}) + 10'(offs.g_offs);
   assign sum_b = $signed({2'b00, luma}) + 10'(offs.b_offs);

   function automatic logic [7:0] clamp8(input logic signed [9:0] s);
      logic [7:0] res;
      if (s[9]) begin
         res = 8'd0;
      end else if (s[8]) begin
         res = 8'hFF;
      end else begin
         res = s[7:0];
      end
      return res;
   endfunction

   assign rgb.red   = clamp8(sum_r);
   assign rgb.green = clamp8(sum_g);
   assign rgb.blue  = clamp8(sum_b);

endmodule
`default_nettype wire

### hw/rtl/yuv422_to_rgb_converter.sv
// Top level: YUV 4:2:2 macropixel to two RGB pixels, integer math with BT.601 coefficient magnitudes.
//
// Usage:
//  - Input: a macropixel transfer happens on a rising edge with start high and
//    busy low. busy is low whenever reset is low, so one macropixel can be
//    sent every cycle.
//  - Output: rsp_strobe marks rsp_data for exactly one cycle; the receiver
//    must take it then, there is no backpressure.
//  - Pipeline: a macropixel is held in the input register after the edge that
//    takes it; its result is then registered in the result register, which drives rsp_data.
//  - Throughput: one macropixel per cycle outside reset; input register, one pass of
//    conversion logic, result register.
//  - Configuration: csr_wdata bit selects byte order (0 = Y0 U Y1 V,
//    1 = U Y0 V Y1); a transfer happens when csr_valid and csr_ready are high.
//    Write it only while no macropixel is in flight.
//  - Reset: synchronous; clears both pipeline valid bits and the byte order
//    register. busy and csr_ready hold off transfers during reset.
`default_nettype none
module yuv422_to_rgb_converter (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire yuvrgb_pkg::yuvrgb_req_type req_data,
   output logic                         rsp_strobe,
   output yuvrgb_pkg::yuvrgb_rsp_type   rsp_data,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire                          csr_wdata
);
   import yuvrgb_pkg::*;

   logic            byte_order_ff;
   logic            byte_order_in;
   logic            in_valid_ff;
   logic            in_valid_in;
   yuvrgb_req_type  in_data_ff;
   logic            rsp_valid_ff;
   yuvrgb_rsp_type  rsp_data_ff;
   yuvrgb_rsp_type  rsp_data_in;
   yuvrgb_samp_type samp;
   yuvrgb_offs_type offs;
   yuvrgb_rgb_type  rgb_first;
   yuvrgb_rgb_type  rgb_second;

   assign busy      = reset;
   assign csr_ready = !reset;

   // Byte order register
   assign byte_order_in = (csr_valid && csr_ready) ? csr_wdata : byte_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_ff <= 1'b0;
      end else begin
         byte_order_ff <= byte_order_in;
      end
   end

   // Input register
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_data_ff <= req_data;
      end
   end

   // Conversion logic
   yuvrgb_unpack u_unpack (
      .macro_px   (in_data_ff),
      .byte_order (byte_order_ff),
      .samp       (samp)
   );

   yuvrgb_chroma u_chroma (
      .u    (samp.u),
      .v    (samp.v),
      .offs (offs)
   );

   yuvrgb_pixel u_pixel_first (
      .luma (samp.y0),
      .offs (offs),
      .rgb  (rgb_first)
   );

   yuvrgb_pixel u_pixel_second (
      .luma (samp.y1),
      .offs (offs),
      .rgb  (rgb_second)
   );

   always_comb begin
      rsp_data_in.red_first    = rgb_first.red;
      rsp_data_in.green_first  = rgb_first.green;
      rsp_data_in.blue_first   = rgb_first.blue;
      rsp_data_in.red_second   = rgb_second.red;
      rsp_data_in.green_second = rgb_second.green;
      rsp_data_in.blue_second  = rgb_second.blue;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

### hw/rtl/yuvrgb_checker.sv
// Port-level checker for the converter, bound to the top level.
`default_nettype none
`include "yuv422_to_rgb_converter_defines.svh"
module yuvrgb_checker (
   input  wire clock,
   input  wire reset,
   input  wire start,
   input  wire busy,
   input  wire rsp_strobe,
   input  wire csr_ready
);

   // Never stalls input or configuration outside reset
   `YUVRGB_ASSERT_IMPLY(a_no_busy, clock, reset, 1'b1, !busy && csr_ready)

   // Every transfer in yields a result once it has passed the input and result registers
   `YUVRGB_ASSERT_NEXT(a_latency, clock, reset, start && !busy, ##1 rsp_strobe)

   // No result without a matching transfer in
   `YUVRGB_ASSERT_IMPLY(a_no_extra, clock, reset, rsp_strobe, $past(start && !busy, 2))

   // Idle input leaves the output idle once it has passed the input and result registers
   `YUVRGB_ASSERT_NEXT(a_idle, clock, reset, !start && $past(!reset), ##1 !rsp_strobe)

endmodule

bind yuv422_to_rgb_converter yuvrgb_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .csr_ready  (csr_ready)
);
`default_nettype wire

### verif/yuvrgb_tb_pkg.sv
`timescale 1ns / 100ps
// Verification package: byte-order register codes shared by the checker and the top.
package yuvrgb_tb_pkg;

   // Values of the byte-order register
   typedef enum logic {
      ORDER_YUYV = 1'b0,
      ORDER_UYVY = 1'b1
   } byte_order_e;

endpackage

### verif/yuv422_to_rgb_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the RGB pair of each accepted macropixel and compares the results.
module yuv422_to_rgb_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire                        busy,
   input  yuvrgb_pkg::yuvrgb_req_type req_data,
   input  wire                        rsp_strobe,
   input  yuvrgb_pkg::yuvrgb_rsp_type rsp_data,
   input  wire                        csr_valid,
   input  wire                        csr_ready,
   input  wire                        csr_wdata,
   output int                         outstanding,
   output int                         mismatch_count,
   output int                         checked_count
);
   import yuvrgb_pkg::*;
   import yuvrgb_tb_pkg::*;

   // BT.601 coefficient magnitudes scaled by 1000
   localparam int CHROMA_BIAS = 128;
   localparam int RED_V       = 1403;
   localparam int GREEN_U     = 344;
   localparam int GREEN_V     = 714;
   localparam int BLUE_U      = 1770;
   localparam int COEF_SCALE  = 1000;
   localparam int PIX_MAX     = 255;
   localparam int REPORT_MAX  = 10;

   localparam string CHAN_NAME [6] = '{"red_first", "green_first", "blue_first",
                                       "red_second", "green_second", "blue_second"};

   byte_order_e    order_now;
   yuvrgb_rsp_type rgb_pairs_due [$];

   // Saturate a signed channel level to 0..255
   function automatic logic [7:0] clamp_channel(input int level);
      if (level < 0)
         return 8'd0;
      if (level > PIX_MAX)
         return 8'(PIX_MAX);
      return 8'(level);
   endfunction

   // One pixel; SV int division truncates toward zero
   function automatic yuvrgb_rgb_type pixel_from_yuv(input int luma, input int cb, input int cr);
      int             cb_off;
      int             cr_off;
      yuvrgb_rgb_type pix;
      cb_off    = cb - CHROMA_BIAS;
      cr_off    = cr - CHROMA_BIAS;
      pix.red   = clamp_channel(luma + (RED_V * cr_off) / COEF_SCALE);
      pix.green = clamp_channel(luma + (GREEN_U * cb_off - GREEN_V * cr_off) / COEF_SCALE);
      pix.blue  = clamp_channel(luma + (BLUE_U * cb_off) / COEF_SCALE);
      return pix;
   endfunction

   // Both pixels of a macropixel under the given byte order
   function automatic yuvrgb_rsp_type rgb_pair_of(input yuvrgb_req_type px,
                                                  input byte_order_e order);
      int             luma_a;
      int             luma_b;
      int             cb;
      int             cr;
      yuvrgb_rgb_type pix_a;
      yuvrgb_rgb_type pix_b;
      if (order == ORDER_UYVY) begin
         cb     = px.byte_zero;
         luma_a = px.byte_one;
         cr     = px.byte_two;
         luma_b = px.byte_three;
      end else begin
         luma_a = px.byte_zero;
         cb     = px.byte_one;
         luma_b = px.byte_two;
         cr     = px.byte_three;
      end
      pix_a = pixel_from_yuv(luma_a, cb, cr);
      pix_b = pixel_from_yuv(luma_b, cb, cr);
      return {pix_a.red, pix_a.green, pix_a.blue, pix_b.red, pix_b.green, pix_b.blue};
   endfunction

   // Watch the three channels at each edge
   always @(posedge clock) begin : watch_channels
      yuvrgb_rsp_type want;
      if (reset) begin
         rgb_pairs_due.delete();
         order_now      = ORDER_YUYV;
         mismatch_count = 0;
         checked_count  = 0;
         outstanding   <= 0;
      end else begin
         // macropixel transfer: predict with the order in force now
         if (start && !busy)
            rgb_pairs_due.push_back(rgb_pair_of(req_data, order_now));

         // result transfer: compare against the oldest prediction
         if (rsp_strobe) begin
            if (rgb_pairs_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%t: result %h with no macropixel pending", $realtime, rsp_data);
            end else begin
               want = rgb_pairs_due.pop_front();
               checked_count++;
               for (int i = 0; i < 6; i++) begin
                  if (rsp_data[8*(5-i) +: 8] !== want[8*(5-i) +: 8]) begin
                     mismatch_count++;
                     if (mismatch_count <= REPORT_MAX)
                        $display("%t: %s expected %0d, got %0d", $realtime, CHAN_NAME[i],
                                 want[8*(5-i) +: 8], rsp_data[8*(5-i) +: 8]);
                  end
               end
            end
         end

         // register write takes effect for later macropixels
         if (csr_valid && csr_ready)
            order_now = byte_order_e'(csr_wdata);

         outstanding <= rgb_pairs_due.size();
      end
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives macropixels and byte-order writes, then gives the verdict.
module testbench;
   import yuvrgb_pkg::*;
   import yuvrgb_tb_pkg::*;

   localparam int IDLE_PCT      = 19;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 225;
   localparam int QUIET_PHASE   = 3;
   localparam int SETTLE_CYCLES = 6;

   // Macropixels written as Y0 U Y1 V under YUYV; the same bytes are reused under UYVY
   localparam yuvrgb_req_type CORNER_PIXELS [12] = '{
      32'h00000000,   // all zero
      32'hFFFFFFFF,   // all full scale
      32'h0080FF80,   // neutral chroma, luma extremes
      32'h800080FF,   // strong negative blue, strong red
      32'h80FF8000,   // strong blue, negative red
      32'hFF0000FF,   // mixed saturation
      32'h00FFFF00,
      32'h807F8081,   // chroma one step off bias: truncation toward zero
      32'h8081807F,
      32'h01807E80,
      32'h80008000,   // green pushed up by the V term and down by the U term
      32'hA55AC33C    // alternating bit patterns
   };

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   yuvrgb_req_type req_data;
   logic           rsp_strobe;
   yuvrgb_rsp_type rsp_data;
   logic           csr_valid;
   logic           csr_ready;
   logic           csr_wdata;

   int outstanding;
   int mismatch_count;
   int checked_count;
   int pixels_sent  = 0;
   int order_writes = 0;
   int stall_cycles = 0;
   bit allow_gaps   = 1'b1;

   yuv422_to_rgb_converter dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   yuv422_to_rgb_checker rgb_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count),
      .checked_count  (checked_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Byte biased toward chroma bias and range edges
   function automatic logic [7:0] pick_byte();
      logic [7:0] edges [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
      if ($urandom_range(99) < 30)
         return edges[$urandom_range(6)];
      return 8'($urandom);
   endfunction

   // One macropixel transfer, with optional idle cycles ahead of it
   task automatic send_macropixel(input yuvrgb_req_type px);
      while (allow_gaps && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      pixels_sent++;
   endtask

   // Stop sending and wait until every predicted pair has come back
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One byte-order register transfer
   task automatic write_byte_order(input byte_order_e order);
      while (allow_gaps && $urandom_range(99) < IDLE_PCT)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= order;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      order_writes++;
   endtask

   // Stimulus
   initial begin
      byte_order_e order;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // corner macropixels under both byte orders
      for (int o = 0; o < 2; o++) begin
         write_byte_order(o == 0 ? ORDER_YUYV : ORDER_UYVY);
         foreach (CORNER_PIXELS[i])
            send_macropixel(CORNER_PIXELS[i]);
         drain_results();
      end

      // random phases; one phase runs back to back with no idle cycles
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 0)
            order = ORDER_UYVY;
         else if (p == 1)
            order = ORDER_YUYV;
         else
            order = byte_order_e'($urandom_range(1));
         allow_gaps = (p != QUIET_PHASE);
         write_byte_order(order);
         repeat (PHASE_ITEMS)
            send_macropixel({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
         drain_results();
      end

      $display("Run covered %0d macropixels (%0d RGB pairs checked), %0d byte-order writes,",
               pixels_sent, checked_count, order_writes);
      $display("both YUYV and UYVY, saturation corners and one gap-free burst.");
      if (mismatch_count == 0 && outstanding == 0)
         $display("** yuv422_to_rgb_converter: PASSED **");
      else
         $display("** yuv422_to_rgb_converter: FAILED **");
      $finish;
   end

   // Watchdog: ends the run after a long stretch with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Watchdog: no transfer in %0d cycles", STALL_LIMIT);
         $display("** yuv422_to_rgb_converter: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/yuvrgb_pkg.sv
hw/rtl/yuvrgb_unpack.sv
hw/rtl/yuvrgb_chroma.sv
hw/rtl/yuvrgb_pixel.sv
hw/rtl/yuv422_to_rgb_converter.sv
hw/rtl/yuvrgb_checker.sv
verif/yuvrgb_tb_pkg.sv
verif/yuv422_to_rgb_checker.sv
verif/testbench.sv
